>>> hw/rtl/fbr_pkg.sv
// Package for the frequency-based replacement directory.
// Holds field widths, register indexes, the entry layout and the sequencer states.
`default_nettype none
package fbr_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int FILE_W       = 16;
    localparam int BLK_W        = 24;
    localparam int CNT_W        = 16;
    localparam int TOT_W        = 5;
    localparam int SEC_W        = 4;
    localparam int POS_W        = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DAT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD   = 2'd2;

    localparam logic [TOT_W-1:0] TOTAL_RST = 5'd16;
    localparam logic [SEC_W-1:0] NEW_RST   = 4'd4;
    localparam logic [SEC_W-1:0] OLD_RST   = 4'd4;

    typedef struct packed {
        logic [FILE_W-1:0] file;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FRONT,
        ST_SORT_RDI,
        ST_SORT_KEY,
        ST_SORT_RDJ,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

>>> hw/rtl/frequency_based_block_replacement_top.sv
// Top level of the frequency-based replacement directory.
// Depends on fbr_pkg and fbr_ram.
`default_nettype none
// The directory keeps a recency-ordered list of (file, block) tags with
// reference counts in one RAM, position 0 being the most recent. Each item
// is handled in order: a linear search reads each position and then checks
// it, then the list is shifted back one position at a time, each a read and
// a write, up to the hit or insert point, the item is written at the front,
// and when the old section needs it an insertion sort by descending count
// runs over the old section, each compare a read and a check. All of this
// goes through the one RAM read port, so the steps run one after another.
// For each old-section entry it visits, the sort reads it, takes it as the
// key and puts it back; its compares are quadratic in the old section size
// in the worst case. A new item is taken only when the sequencer is
// idle; the result register lets the next item enter while a result waits.
// Configuration must be written only while idle.
module frequency_based_block_replacement_top
    import fbr_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [FILE_W-1:0]    i_file_id,
    input  wire logic [BLK_W-1:0]     i_block_number,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_hit,
    output logic [POS_W-1:0]          o_hit_position,
    output logic                      o_evicted,
    output logic [FILE_W-1:0]         o_evicted_file,
    output logic [BLK_W-1:0]          o_evicted_block,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > TOT_W) ? CW : TOT_W;
    localparam logic [IW-1:0] CAP_V = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE   = IW'(1);

    // configuration
    logic [TOT_W-1:0] r_total;
    logic [SEC_W-1:0] r_new_sz, r_old_sz;

    // sequencer
    t_state r_state, n_state;
    logic [IW-1:0] r_occ, n_occ;
    logic [IW-1:0] r_k, n_k;     // search index
    logic [IW-1:0] r_j, n_j;     // shift / insertion index
    logic [IW-1:0] r_i, n_i;     // sort outer index
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_sort, n_sort;
    logic [FILE_W-1:0] r_file, n_file;
    logic [BLK_W-1:0] r_blk, n_blk;
    t_entry r_key, n_key;
    logic r_hit, n_hit, r_ev, n_ev;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [FILE_W-1:0] r_evf, n_evf;
    logic [BLK_W-1:0] r_evb, n_evb;

    // result register
    logic r_ov;
    logic r_o_hit, r_o_ev;
    logic [POS_W-1:0] r_o_pos;
    logic [FILE_W-1:0] r_o_evf;
    logic [BLK_W-1:0] r_o_evb;

    // RAM port
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_entry ram_wdata, ram_rdata;

    fbr_ram #(.WIDTH($bits(t_entry)), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // section boundaries
    logic [IW-1:0] eff_t, new_v, old_v, start, pos;
    logic tag_match, out_free;
    always_comb begin
        eff_t = (IW'(r_total) < CAP_V) ? IW'(r_total) : CAP_V;
        new_v = IW'(r_new_sz);
        old_v = IW'(r_old_sz);
        start = (eff_t > old_v) ? eff_t - old_v : '0;
        pos   = r_k + ONE;
        tag_match = (ram_rdata.file == r_file) && (ram_rdata.blk == r_blk);
        out_free  = !r_ov || !i_stall;
    end

    assign o_stall = (r_state != ST_IDLE);

    // next state and datapath updates
    always_comb begin
        n_state = r_state;
        n_occ = r_occ; n_k = r_k; n_j = r_j; n_i = r_i;
        n_cnt = r_cnt; n_sort = r_sort; n_file = r_file; n_blk = r_blk;
        n_key = r_key; n_hit = r_hit; n_ev = r_ev; n_pos = r_pos;
        n_evf = r_evf; n_evb = r_evb;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_file = i_file_id;
                    n_blk  = i_block_number;
                    n_k = '0; n_hit = 1'b0; n_pos = '0;
                    n_ev = 1'b0; n_evf = '0; n_evb = '0;
                    n_cnt = CNT_W'(1); n_sort = 1'b0; n_j = '0;
                    if (r_occ != '0) begin
                        n_state = ST_SRCH_RD;
                    end else if (eff_t == '0) begin
                        // nothing may stay: the new tag itself goes out
                        n_ev = 1'b1; n_evf = i_file_id; n_evb = i_block_number;
                        n_state = ST_OUT;
                    end else begin
                        n_occ = ONE;
                        n_state = ST_FRONT;
                    end
                end
            end
            ST_SRCH_RD: n_state = ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if (tag_match) begin
                    n_hit = 1'b1;
                    n_pos = pos[POS_W-1:0];
                    n_cnt = ram_rdata.cnt;
                    n_sort = 1'b0;
                    if (pos > new_v) begin
                        if (ram_rdata.cnt != '1) begin
                            n_cnt = ram_rdata.cnt + CNT_W'(1);
                        end
                        n_sort = (eff_t < old_v) || (pos > eff_t - old_v);
                    end
                    n_j = r_k;
                    n_state = (r_k == '0) ? ST_FRONT : ST_SHIFT_RD;
                end else if (pos == r_occ) begin
                    // miss: the last read entry is the tail
                    n_cnt = CNT_W'(1);
                    if (r_occ >= eff_t) begin
                        n_ev = 1'b1; n_evf = ram_rdata.file; n_evb = ram_rdata.blk;
                        n_j = r_occ - ONE;
                        n_sort = 1'b1;
                    end else begin
                        n_j = r_occ;
                        n_occ = r_occ + ONE;
                        n_sort = 1'b0;
                    end
                    n_state = (n_j == '0) ? ST_FRONT : ST_SHIFT_RD;
                end else begin
                    n_k = pos;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_WR;
            ST_SHIFT_WR: begin
                n_j = r_j - ONE;
                n_state = (r_j == ONE) ? ST_FRONT : ST_SHIFT_RD;
            end
            ST_FRONT: begin
                n_i = start + ONE;
                n_state = (r_sort && (start + ONE < r_occ)) ? ST_SORT_RDI : ST_OUT;
            end
            ST_SORT_RDI: n_state = ST_SORT_KEY;
            ST_SORT_KEY: begin
                n_key = ram_rdata;
                n_j = r_i;
                n_state = ST_SORT_RDJ;
            end
            ST_SORT_RDJ: n_state = ST_SORT_CMP;
            ST_SORT_CMP: begin
                if (ram_rdata.cnt < r_key.cnt) begin
                    n_j = r_j - ONE;
                    n_state = (r_j - ONE > start) ? ST_SORT_RDJ : ST_SORT_PUT;
                end else begin
                    n_state = ST_SORT_PUT;
                end
            end
            ST_SORT_PUT: begin
                n_i = r_i + ONE;
                n_state = (r_i + ONE < r_occ) ? ST_SORT_RDI : ST_OUT;
            end
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM control
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_k[AW-1:0];
        unique case (r_state)
            ST_SHIFT_RD: ram_raddr = AW'(r_j - ONE);
            ST_SHIFT_WR: ram_we = 1'b1;
            ST_FRONT: begin
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{file: r_file, blk: r_blk, cnt: r_cnt};
            end
            ST_SORT_RDI: ram_raddr = r_i[AW-1:0];
            ST_SORT_RDJ: ram_raddr = AW'(r_j - ONE);
            ST_SORT_CMP: ram_we = (ram_rdata.cnt < r_key.cnt);
            ST_SORT_PUT: begin
                ram_we = 1'b1;
                ram_wdata = r_key;
            end
            default: ram_raddr = r_k[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_occ <= '0;
            r_ov <= 1'b0;
            r_total <= TOTAL_RST;
            r_new_sz <= NEW_RST;
            r_old_sz <= OLD_RST;
        end else begin
            r_state <= n_state;
            r_occ <= n_occ;
            // load the result when the sequencer finishes, drop it when taken
            if (r_state == ST_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TOTAL: r_total <= i_cfg_data;
                    CFG_NEW:   r_new_sz <= i_cfg_data[SEC_W-1:0];
                    CFG_OLD:   r_old_sz <= i_cfg_data[SEC_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k; r_j <= n_j; r_i <= n_i; r_cnt <= n_cnt; r_sort <= n_sort;
        r_file <= n_file; r_blk <= n_blk; r_key <= n_key;
        r_hit <= n_hit; r_ev <= n_ev; r_pos <= n_pos; r_evf <= n_evf; r_evb <= n_evb;
        if (r_state == ST_OUT && out_free) begin
            r_o_hit <= r_hit;
            r_o_pos <= r_pos;
            r_o_ev  <= r_ev;
            r_o_evf <= r_evf;
            r_o_evb <= r_evb;
        end
    end

    assign o_valid         = r_ov;
    assign o_hit           = r_o_hit;
    assign o_hit_position  = r_o_pos;
    assign o_evicted       = r_o_ev;
    assign o_evicted_file  = r_o_evf;
    assign o_evicted_block = r_o_evb;
endmodule
`default_nettype wire

>>> hw/rtl/fbr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
`default_nettype none
module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sim/frequency_based_block_replacement_top_tb.sv
// Self-checking testbench for the frequency-based replacement directory.
// Drives requests through valid/stall, predicts hit, position and eviction per item.
// Depends on fbr_pkg and frequency_based_block_replacement_top.
`default_nettype none
module frequency_based_block_replacement_top_tb
    import fbr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 16;
    localparam int RAND_ITEMS = 1300;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  pos;
        logic              evicted;
        logic [FILE_W-1:0] efile;
        logic [BLK_W-1:0]  eblk;
    } t_outcome;

    // One row of the directed table: request, and optionally a typed-in outcome.
    typedef struct {
        logic [FILE_W-1:0] file;
        logic [BLK_W-1:0]  blk;
        bit                typed;
        t_outcome          res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [FILE_W-1:0] i_file_id = '0;
    logic [BLK_W-1:0] i_block_number = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic o_hit;
    logic [POS_W-1:0] o_hit_position;
    logic o_evicted;
    logic [FILE_W-1:0] o_evicted_file;
    logic [BLK_W-1:0] o_evicted_block;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TOTAL;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    frequency_based_block_replacement_top #(.CAPACITY(CAP)) dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state: shadow directory and registers.
    logic [FILE_W-1:0] dir_file [CAP];
    logic [BLK_W-1:0]  dir_blk  [CAP];
    logic [CNT_W-1:0]  dir_cnt  [CAP];
    int unsigned       dir_occ;
    int unsigned       reg_total, reg_new, reg_old;

    t_outcome outcome_q[$];
    int  fail_count = 0;
    longint cycle_count = 0;
    bit  long_hold = 1'b0;

    function automatic int unsigned cap_total();
        return (reg_total < CAP) ? reg_total : CAP;
    endfunction

    // Stable insertion sort by descending count over the old section.
    function automatic void resort_old();
        int unsigned t, start, i, j;
        logic [FILE_W-1:0] f;
        logic [BLK_W-1:0] b;
        logic [CNT_W-1:0] c;
        t = cap_total();
        start = (t > reg_old) ? t - reg_old : 0;
        for (i = start + 1; i < dir_occ; i++) begin
            f = dir_file[i]; b = dir_blk[i]; c = dir_cnt[i];
            j = i;
            while (j > start && dir_cnt[j-1] < c) begin
                dir_file[j] = dir_file[j-1];
                dir_blk[j]  = dir_blk[j-1];
                dir_cnt[j]  = dir_cnt[j-1];
                j--;
            end
            dir_file[j] = f; dir_blk[j] = b; dir_cnt[j] = c;
        end
    endfunction

    function automatic void move_to_front(int unsigned k, logic [FILE_W-1:0] f,
                                          logic [BLK_W-1:0] b, logic [CNT_W-1:0] c);
        while (k > 0) begin
            dir_file[k] = dir_file[k-1];
            dir_blk[k]  = dir_blk[k-1];
            dir_cnt[k]  = dir_cnt[k-1];
            k--;
        end
        dir_file[0] = f; dir_blk[0] = b; dir_cnt[0] = c;
    endfunction

    function automatic t_outcome lookup_block(logic [FILE_W-1:0] f, logic [BLK_W-1:0] b);
        t_outcome r;
        int unsigned t, k, p;
        logic [CNT_W-1:0] c;
        bit in_old;
        r = '0;
        t = cap_total();
        for (k = 0; k < dir_occ; k++) begin
            if (dir_file[k] == f && dir_blk[k] == b) begin
                p = k + 1;
                c = dir_cnt[k];
                in_old = 1'b0;
                if (p > reg_new) begin
                    if (c != '1) c++;
                    in_old = (t < reg_old) || (p > t - reg_old);
                end
                move_to_front(k, f, b, c);
                if (in_old) resort_old();
                r.hit = 1'b1;
                r.pos = p[POS_W-1:0];
                return r;
            end
        end
        if (dir_occ >= t) begin
            r.evicted = 1'b1;
            if (dir_occ == 0) begin
                // Zero total: the new block itself falls out.
                r.efile = f; r.eblk = b;
                return r;
            end
            r.efile = dir_file[dir_occ-1];
            r.eblk  = dir_blk[dir_occ-1];
            move_to_front(dir_occ - 1, f, b, CNT_W'(1));
            resort_old();
        end else begin
            dir_occ++;
            move_to_front(dir_occ - 1, f, b, CNT_W'(1));
        end
        return r;
    endfunction

    // Cycle counter doubles as the watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall, mostly short, a few long; hold fully during long_hold.
    initial begin : receiver
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end else begin
                gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                    : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
                i_stall <= (gap != 0);
                repeat (gap > 0 ? gap : 1) @(posedge i_clk);
            end
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome want, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_hit, o_hit_position, o_evicted, o_evicted_file, o_evicted_block};
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                fail_count++;
            end else begin
                want = outcome_q.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
                    fail_count++;
                end
                if (got.pos !== want.pos) begin
                    $display("%0t: hit_position exp %0d got %0d", $time, want.pos, got.pos);
                    fail_count++;
                end
                if (got.evicted !== want.evicted) begin
                    $display("%0t: evicted exp %0d got %0d", $time, want.evicted,
                             got.evicted);
                    fail_count++;
                end
                if (got.efile !== want.efile) begin
                    $display("%0t: evicted_file exp %h got %h", $time, want.efile, got.efile);
                    fail_count++;
                end
                if (got.eblk !== want.eblk) begin
                    $display("%0t: evicted_block exp %h got %h", $time, want.eblk, got.eblk);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item and hold it until accepted; predict at acceptance.
    task automatic send_block(logic [FILE_W-1:0] f, logic [BLK_W-1:0] b,
                              bit typed = 1'b0, t_outcome res = '0);
        t_outcome pred;
        int gap;
        i_valid <= 1'b1;
        i_file_id <= f;
        i_block_number <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = lookup_block(f, b);
        if (typed && pred !== res) begin
            $display("%0t: table row exp %p predictor %p", $time, res, pred);
            fail_count++;
        end
        outcome_q.push_back(typed ? res : pred);
        // Sender gap: drop valid only when a gap follows.
        gap = ($urandom_range(0, 24) == 0) ? $urandom_range(8, 50)
            : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every result is in, then let the sequencer settle.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DAT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TOTAL: reg_total = val & 5'h1f;
            CFG_NEW:   reg_new   = val & 4'hf;
            CFG_OLD:   reg_old   = val & 4'hf;
            default: ;
        endcase
    endtask

    // Random request from a small working set so hits, promotions and evictions occur.
    task automatic random_block(int unsigned pool);
        logic [FILE_W-1:0] f;
        logic [BLK_W-1:0] b;
        int unsigned sel;
        if ($urandom_range(0, 9) == 0) begin
            f = FILE_W'($urandom); b = BLK_W'($urandom);   // noise over the full field ranges
        end else begin
            sel = $urandom_range(0, pool - 1);
            f = (sel[0] ? 16'hffff : 16'h0000) ^ sel[FILE_W-1:0];
            b = (sel[1] ? 24'hffffff : 24'h000000) ^ {sel[7:0], 16'h0};
        end
        send_block(f, b);
    endtask

    initial begin : stimulus
        t_row rows[$];
        int phase, n, lvl;
        int unsigned tot_set [6] = '{16, 2, 31, 8, 0, 5};
        int unsigned new_set [6] = '{4, 1, 15, 15, 1, 2};
        int unsigned old_set [6] = '{4, 1, 15, 1, 15, 3};
        int unsigned pool_set[6] = '{20, 4, 24, 12, 3, 8};

        reg_total = TOTAL_RST; reg_new = NEW_RST; reg_old = OLD_RST;
        dir_occ = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset settings: cold misses, hits at various depths,
        // field extremes, overflow eviction of the oldest entry.
        rows.push_back('{16'h0000, 24'h000000, 1, '{0, 0, 0, 0, 0}});
        rows.push_back('{16'hffff, 24'hffffff, 1, '{0, 0, 0, 0, 0}});
        rows.push_back('{16'h0000, 24'h000000, 1, '{1, 2, 0, 0, 0}});
        rows.push_back('{16'hffff, 24'h000000, 1, '{0, 0, 0, 0, 0}});
        rows.push_back('{16'h0000, 24'hffffff, 1, '{0, 0, 0, 0, 0}});
        for (int i = 1; i <= 12; i++) rows.push_back('{i[15:0], i[23:0], 0, '0});
        rows.push_back('{16'hffff, 24'hffffff, 0, '0});   // deep hit, old section
        rows.push_back('{16'h0000, 24'h000000, 0, '0});
        rows.push_back('{16'h5555, 24'haaaaaa, 0, '0});   // overflow evicts
        rows.push_back('{16'haaaa, 24'h555555, 0, '0});
        rows.push_back('{16'h0001, 24'h000001, 0, '0});
        foreach (rows[i]) send_block(rows[i].file, rows[i].blk, rows[i].typed, rows[i].res);
        drain();

        // Random phases over several register settings, extremes among them.
        for (phase = 0; phase < 6; phase++) begin
            write_reg(CFG_TOTAL, tot_set[phase]);
            write_reg(CFG_NEW, new_set[phase]);
            write_reg(CFG_OLD, old_set[phase]);
            n = RAND_ITEMS / 6;
            for (lvl = 0; lvl < n; lvl++) begin
                // Early in the first phase, hold the receiver off for a long stretch.
                if (phase == 0 && lvl == 40) long_hold = 1'b1;
                if (phase == 0 && lvl == 46) long_hold = 1'b0;
                random_block(pool_set[phase]);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Release the long hold after a counted stretch even if few items were offered.
    initial begin : hold_release
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                held++;
                if (held >= 400) long_hold = 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
